// ===== hw/rtl/line_substring_filter_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the line substring filter
// Clocked concurrent assertion helpers shared by lsf_queue and lsf_back.
// ----------------------------------------------------------------------------
`ifndef LINE_SUBSTRING_FILTER_CORE_ASSERT_SVH
`define LINE_SUBSTRING_FILTER_CORE_ASSERT_SVH

// Assertion checked outside reset
`define LSF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lsf assertion failed");

// Implication checked outside reset
`define LSF_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  `LSF_ASSERT(lbl, clk, rst_n, (pre) |-> (post))

// Next-cycle implication checked outside reset
`define LSF_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  `LSF_ASSERT(lbl, clk, rst_n, (pre) |=> (post))

`endif

// ===== hw/rtl/lsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lsf_pkg
// Types, constants and helpers shared by the line substring filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsf_pkg;

  // Pattern storage is fixed by the register map: four 64-bit words
  localparam int PATTERN_MAX_DEFAULT = 32;
  localparam int PATTERN_WORDS       = 4;
  localparam int WORD_W              = 64;
  localparam int LEN_W               = 6;
  localparam int COUNT_W             = 32;
  localparam int CFG_INDEX_W         = 3;

  // Line result queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_BIT     = 8'h20;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CHARS_LO   = 3'd0,
    REG_CHARS_MID  = 3'd1,
    REG_CHARS_HIGH = 3'd2,
    REG_CHARS_TOP  = 3'd3,
    REG_LENGTH     = 3'd4,
    REG_IGNORE     = 3'd5,
    REG_INVERT     = 3'd6
  } cfg_reg_e;

  // Configuration seen by the front end
  typedef struct packed {
    logic [PATTERN_WORDS-1:0][WORD_W-1:0] chars;
    logic [LEN_W-1:0]                     length;
    logic                                 ignore_case;
    logic                                 invert;
  } lsf_cfg_t;

  // One finished line, queued between front and back
  typedef struct packed {
    logic selected;
    logic last;
  } lsf_rec_t;

  // ASCII upper-case letters fold to lower case when enabled
  function automatic logic [7:0] lsf_fold(logic [7:0] c, logic ic);
    logic [7:0] r;
    r = c;
    if (ic && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
      r = c | CASE_BIT;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/line_substring_filter_core.sv =====
// ----------------------------------------------------------------------------
// line_substring_filter_core
// Per-line fixed-string filter over a byte stream, with saturating count.
// ----------------------------------------------------------------------------
// Channel   Dir  Transfer                     Contents
// s_axis    in   tvalid & tready              tdata[7:0] text byte, tlast end of text
// m_axis    out  tvalid & tready              tdata[31:0] count, tuser selected,
//                                             tlast final line
// cfg       in   cfg_valid_i & cfg_ready_o    cfg_index_i register, cfg_data_i value
//
// One byte per cycle; the matcher vector updates in the same cycle as the
// byte transfer. A line result passes through the queue, then the result
// register, before it reaches m_axis. s_axis stalls only when the two-entry line
// queue is full; cfg is always ready. Reset clears the matcher, queue and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_substring_filter_core
  import lsf_pkg::*;
#(
  parameter int PatternMax = PATTERN_MAX_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [7:0]             s_axis_tdata_i,   // [7:0] text_byte
  input  logic                   s_axis_tlast_i,   // end_of_text
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [COUNT_W-1:0]     m_axis_tdata_o,   // [31:0] selected_count
  output logic                   m_axis_tuser_o,   // [0] line_selected
  output logic                   m_axis_tlast_o,   // final_line
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]      cfg_data_i
);

  lsf_cfg_t cfg_q;
  lsf_rec_t push_rec, pop_rec;
  logic     accept, push, full, q_valid, pop;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CHARS_LO:   cfg_q.chars[0]    <= cfg_data_i;
        REG_CHARS_MID:  cfg_q.chars[1]    <= cfg_data_i;
        REG_CHARS_HIGH: cfg_q.chars[2]    <= cfg_data_i;
        REG_CHARS_TOP:  cfg_q.chars[3]    <= cfg_data_i;
        REG_LENGTH:     cfg_q.length      <= cfg_data_i[LEN_W-1:0];
        REG_IGNORE:     cfg_q.ignore_case <= cfg_data_i[0];
        REG_INVERT:     cfg_q.invert      <= cfg_data_i[0];
        default:        ;
      endcase
    end
  end

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  lsf_front #(
    .PatternMax(PatternMax)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .accept_i(accept),
    .byte_i  (s_axis_tdata_i),
    .last_i  (s_axis_tlast_i),
    .push_o  (push),
    .rec_o   (push_rec)
  );

  lsf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (push_rec),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .rec_o  (pop_rec)
  );

  lsf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .rec_i         (pop_rec),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_selected_o(m_axis_tuser_o),
    .out_count_o   (m_axis_tdata_o),
    .out_last_o    (m_axis_tlast_o)
  );

endmodule

// ===== hw/rtl/lsf_front.sv =====
// ----------------------------------------------------------------------------
// lsf_front
// Byte intake: shift-and matcher, line-end detection, selection decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsf_front
  import lsf_pkg::*;
#(
  parameter int PatternMax = PATTERN_MAX_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lsf_cfg_t   cfg_i,
  input  logic       accept_i,   // byte transfer this cycle
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic       push_o,     // line finished, record valid
  output lsf_rec_t   rec_o
);

  logic [PatternMax-1:0] vec_q, vec_d, mask, len_sel;
  logic                  has_q, has_d, busy_q, busy_d;
  logic [7:0]            fc;
  logic [LEN_W-1:0]      len_eff;
  logic                  is_nl, line_end, has_new, busy_new, match;

  assign fc      = lsf_fold(byte_i, cfg_i.ignore_case);
  assign len_eff = (cfg_i.length > LEN_W'(PatternMax)) ? LEN_W'(PatternMax) : cfg_i.length;

  // Per-character compare lanes and the one-hot tap for the full match
  for (genvar g = 0; g < PatternMax; g++) begin : g_lane
    assign mask[g] = lsf_fold(cfg_i.chars[g / 8][(g % 8) * 8 +: 8],
                              cfg_i.ignore_case) == fc;
    assign len_sel[g] = (len_eff == LEN_W'(g + 1));
  end

  // Match update and line close
  always_comb begin
    is_nl    = (byte_i == CHAR_NEWLINE);
    line_end = is_nl || last_i;
    vec_d    = vec_q;
    has_new  = has_q;
    busy_new = busy_q;
    if (!is_nl) begin
      vec_d    = ((vec_q << 1) | PatternMax'(1)) & mask;
      busy_new = 1'b1;
      if (|(vec_d & len_sel)) begin
        has_new = 1'b1;
      end
    end
    match          = (len_eff == '0) ? busy_new : has_new;
    rec_o.selected = match ^ cfg_i.invert;
    rec_o.last     = last_i;
    push_o         = accept_i && line_end;
    has_d          = has_new;
    busy_d         = busy_new;
    if (line_end) begin
      vec_d  = '0;
      has_d  = 1'b0;
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q  <= '0;
      has_q  <= 1'b0;
      busy_q <= 1'b0;
    end else if (accept_i) begin
      vec_q  <= vec_d;
      has_q  <= has_d;
      busy_q <= busy_d;
    end
  end

endmodule

// ===== hw/rtl/lsf_queue.sv =====
// ----------------------------------------------------------------------------
// lsf_queue
// Short FIFO of finished-line records between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_substring_filter_core_assert.svh"

module lsf_queue
  import lsf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lsf_rec_t rec_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output lsf_rec_t rec_o
);

  lsf_rec_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_q];

  // Pointer and fill update
  always_comb begin
    wr_d  = push_i ? QPTR_W'((QCNT_W'(wr_q) + 1'b1) % QUEUE_DEPTH) : wr_q;
    rd_d  = pop_i ? QPTR_W'((QCNT_W'(rd_q) + 1'b1) % QUEUE_DEPTH) : rd_q;
    cnt_d = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  `LSF_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, full_o, !push_i || pop_i)
  `LSF_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, pop_i, valid_o)
  `LSF_ASSERT_NXT(a_fill_up, clk_i, rst_ni, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1)

endmodule

// ===== hw/rtl/lsf_back.sv =====
// ----------------------------------------------------------------------------
// lsf_back
// Running selected-line count and the registered result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_substring_filter_core_assert.svh"

module lsf_back
  import lsf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  lsf_rec_t           rec_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_selected_o,
  output logic [COUNT_W-1:0] out_count_o,
  output logic               out_last_o
);

  logic               valid_q, valid_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               sel_q, last_q;

  // Take a record when the result stage is empty or draining
  always_comb begin
    pop_o   = valid_i && (!valid_q || out_ready_i);
    valid_d = pop_o || (valid_q && !out_ready_i);
    count_d = count_q;
    if (pop_o && rec_i.selected && (count_q != '1)) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      count_q <= '0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sel_q  <= rec_i.selected;
      last_q <= rec_i.last;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_selected_o = sel_q;
  assign out_count_o    = count_q;
  assign out_last_o     = last_q;

  `LSF_ASSERT_NXT(a_count_mono, clk_i, rst_ni, 1'b1, count_q >= $past(count_q))
  `LSF_ASSERT_NXT(a_count_step, clk_i, rst_ni, 1'b1, (count_q - $past(count_q)) <= 1)
  `LSF_ASSERT_NXT(a_count_hold, clk_i, rst_ni, !pop_o, $stable(count_q))

endmodule
